FILE: src/size_class_free_list_allocator_macros.svh
// Assertion macros shared by the checker of the size-class block manager.
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SCFL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SCFL_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/scfl_pkg.sv
// Package with the types and constants of the size-class block manager.
`timescale 1ns / 1ps

package scfl_pkg;

    localparam int LOG_MIN_SIZE_DEF = 5;
    localparam int LOG_MAX_SIZE_DEF = 12;
    localparam int MAX_DEPTH_DEF    = 64;
    localparam int HEADER_BYTES     = 8;

    localparam int REQ_W    = 20;
    localparam int HANDLE_W = 32;
    localparam int CLASS_W  = 4;
    localparam int BYTES_W  = 21;
    localparam int LIMIT_W  = 7;
    localparam int CLS_W    = 3;

    localparam logic [LIMIT_W-1:0] DEPTH_LIMIT_RESET = 7'd64;
    localparam logic signed [CLASS_W-1:0] CLASS_NONE = -4'sd1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_FRESH    = 3'd1,
        ST_OVERSIZE = 3'd2,
        ST_KEPT     = 3'd3,
        ST_RELEASED = 3'd4,
        ST_NULL     = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_DECODE = 2'd1,
        S_READ   = 2'd2,
        S_RESP   = 2'd3
    } state_t;

    typedef struct packed {
        logic capture;
        logic decode;
        logic load_handle;
        logic cfg_we;
    } ctl_t;

    typedef struct packed {
        logic pop;
    } sts_t;

endpackage

FILE: src/scfl_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module scfl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/scfl_datapath.sv
// Datapath: request registers, class mapping, stack depths, stack memory and result registers.
`timescale 1ns / 1ps

module scfl_datapath #(
    parameter int LOG_MIN_SIZE = scfl_pkg::LOG_MIN_SIZE_DEF,
    parameter int LOG_MAX_SIZE = scfl_pkg::LOG_MAX_SIZE_DEF,
    parameter int MAX_DEPTH    = scfl_pkg::MAX_DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  scfl_pkg::ctl_t                        ctl,
    output scfl_pkg::sts_t                        sts,
    input  logic                                  command,
    input  logic [scfl_pkg::REQ_W-1:0]            request_bytes,
    input  logic [scfl_pkg::HANDLE_W-1:0]         block_handle,
    input  logic signed [scfl_pkg::CLASS_W-1:0]   block_class,
    input  logic [scfl_pkg::LIMIT_W-1:0]          cfg_data,
    output logic [2:0]                            status,
    output logic [scfl_pkg::HANDLE_W-1:0]         out_handle,
    output logic signed [scfl_pkg::CLASS_W-1:0]   out_class,
    output logic [scfl_pkg::BYTES_W-1:0]          block_bytes
);

    localparam int NUM_CLASSES = LOG_MAX_SIZE - LOG_MIN_SIZE + 1;
    localparam int CIW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int LW = (DW > scfl_pkg::LIMIT_W) ? DW : scfl_pkg::LIMIT_W;
    localparam int RAM_DEPTH = NUM_CLASSES * MAX_DEPTH;
    localparam int AW = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
    localparam int BW = scfl_pkg::BYTES_W;
    localparam logic [BW-1:0] MIN_BYTES = BW'(64'd1 << LOG_MIN_SIZE);
    localparam logic [BW-1:0] MAX_BYTES = BW'(64'd1 << LOG_MAX_SIZE);

    logic                                 command_reg;
    logic [scfl_pkg::REQ_W-1:0]           request_bytes_reg;
    logic [scfl_pkg::HANDLE_W-1:0]        block_handle_reg;
    logic signed [scfl_pkg::CLASS_W-1:0]  block_class_reg;

    scfl_pkg::status_t                    status_reg;
    scfl_pkg::status_t                    status_next;
    logic [scfl_pkg::HANDLE_W-1:0]        out_handle_reg;
    logic signed [scfl_pkg::CLASS_W-1:0]  out_class_reg;
    logic signed [scfl_pkg::CLASS_W-1:0]  out_class_next;
    logic [BW-1:0]                        block_bytes_reg;
    logic [BW-1:0]                        block_bytes_next;

    logic [DW-1:0]                        depth_reg [NUM_CLASSES];
    logic [DW-1:0]                        depth_next [NUM_CLASSES];
    logic [scfl_pkg::LIMIT_W-1:0]         depth_limit_reg;
    logic [scfl_pkg::LIMIT_W-1:0]         depth_limit_next;

    logic [BW-1:0]                        total;
    logic                                 oversize;
    logic [scfl_pkg::CLS_W-1:0]           alloc_cls;
    logic                                 free_valid;
    logic [scfl_pkg::CLS_W-1:0]           sel_cls;
    logic [CIW-1:0]                       sel_idx;
    logic [DW-1:0]                        depth_sel;
    logic [LW-1:0]                        limit;
    logic [BW-1:0]                        sel_bytes;
    logic                                 do_pop;
    logic                                 do_push;
    logic [DW-1:0]                        slot;
    logic [AW-1:0]                        stack_addr;
    logic [scfl_pkg::HANDLE_W-1:0]        ram_rdata;

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            command_reg       <= command;
            request_bytes_reg <= request_bytes;
            block_handle_reg  <= block_handle;
            block_class_reg   <= block_class;
        end
        if (ctl.decode)
        begin
            status_reg      <= status_next;
            out_class_reg   <= out_class_next;
            block_bytes_reg <= block_bytes_next;
            out_handle_reg  <= '0;
        end
        else if (ctl.load_handle)
        begin
            out_handle_reg <= ram_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                depth_reg[i] <= '0;
            end
            depth_limit_reg <= scfl_pkg::DEPTH_LIMIT_RESET;
        end
        else
        begin
            depth_reg       <= depth_next;
            depth_limit_reg <= depth_limit_next;
        end
    end

    assign total    = {1'b0, request_bytes_reg} + BW'(scfl_pkg::HEADER_BYTES);
    assign oversize = total > MAX_BYTES;

    always_comb
    begin
        alloc_cls = '0;
        for (int i = 0; i < NUM_CLASSES - 1; i++)
        begin
            if ((MIN_BYTES << i) < total)
            begin
                alloc_cls = scfl_pkg::CLS_W'(i + 1);
            end
        end
    end

    assign free_valid = !block_class_reg[scfl_pkg::CLASS_W-1]
        && ({1'b0, block_class_reg[scfl_pkg::CLS_W-1:0]} < scfl_pkg::CLASS_W'(NUM_CLASSES));
    assign sel_cls    = (command_reg == scfl_pkg::CMD_ALLOC)
        ? alloc_cls : block_class_reg[scfl_pkg::CLS_W-1:0];
    assign sel_idx    = CIW'(sel_cls);
    assign depth_sel  = depth_reg[sel_idx];
    assign sel_bytes  = MIN_BYTES << sel_cls;
    assign limit      = (LW'(depth_limit_reg) < LW'(MAX_DEPTH))
        ? LW'(depth_limit_reg) : LW'(MAX_DEPTH);

    always_comb
    begin
        status_next      = scfl_pkg::ST_RELEASED;
        out_class_next   = block_class_reg;
        block_bytes_next = '0;
        do_pop           = 1'b0;
        do_push          = 1'b0;
        if (command_reg == scfl_pkg::CMD_ALLOC)
        begin
            if (oversize)
            begin
                status_next      = scfl_pkg::ST_OVERSIZE;
                out_class_next   = scfl_pkg::CLASS_NONE;
                block_bytes_next = total;
            end
            else
            begin
                out_class_next   = {1'b0, alloc_cls};
                block_bytes_next = sel_bytes;
                if (depth_sel != '0)
                begin
                    status_next = scfl_pkg::ST_HIT;
                    do_pop      = 1'b1;
                end
                else
                begin
                    status_next = scfl_pkg::ST_FRESH;
                end
            end
        end
        else if (block_handle_reg == '0)
        begin
            status_next = scfl_pkg::ST_NULL;
        end
        else if (free_valid)
        begin
            block_bytes_next = sel_bytes;
            if (LW'(depth_sel) < limit)
            begin
                status_next = scfl_pkg::ST_KEPT;
                do_push     = 1'b1;
            end
        end
    end

    assign slot       = do_pop ? depth_sel - DW'(1) : depth_sel;
    assign stack_addr = AW'(sel_idx) * AW'(MAX_DEPTH) + AW'(slot);
    assign sts.pop    = do_pop;

    always_comb
    begin
        depth_next       = depth_reg;
        depth_limit_next = depth_limit_reg;
        if (ctl.decode && do_pop)
        begin
            depth_next[sel_idx] = depth_sel - DW'(1);
        end
        if (ctl.decode && do_push)
        begin
            depth_next[sel_idx] = depth_sel + DW'(1);
        end
        if (ctl.cfg_we)
        begin
            depth_limit_next = cfg_data;
        end
    end

    scfl_ram #(
        .WIDTH(scfl_pkg::HANDLE_W),
        .DEPTH(RAM_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ctl.decode && do_push),
        .waddr (stack_addr),
        .wdata (block_handle_reg),
        .re    (ctl.decode && do_pop),
        .raddr (stack_addr),
        .rdata (ram_rdata)
    );

    assign status      = status_reg;
    assign out_handle  = out_handle_reg;
    assign out_class   = out_class_reg;
    assign block_bytes = block_bytes_reg;

endmodule

FILE: src/scfl_ctrl.sv
// Controller state machine that sequences one request through the datapath.
`timescale 1ns / 1ps

module scfl_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           cfg_valid,
    input  scfl_pkg::sts_t sts,
    output scfl_pkg::ctl_t ctl,
    output logic           busy,
    output logic           done,
    output logic           cfg_ready
);

    scfl_pkg::state_t state_reg;
    scfl_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scfl_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        ctl             = '0;
        busy            = 1'b1;
        done            = 1'b0;
        cfg_ready       = 1'b0;
        unique case (state_reg)
            scfl_pkg::S_IDLE:
            begin
                busy       = 1'b0;
                cfg_ready  = 1'b1;
                ctl.cfg_we = cfg_valid;
                if (start)
                begin
                    ctl.capture = 1'b1;
                    state_next  = scfl_pkg::S_DECODE;
                end
            end
            scfl_pkg::S_DECODE:
            begin
                ctl.decode = 1'b1;
                state_next = sts.pop ? scfl_pkg::S_READ : scfl_pkg::S_RESP;
            end
            scfl_pkg::S_READ:
            begin
                ctl.load_handle = 1'b1;
                state_next      = scfl_pkg::S_RESP;
            end
            scfl_pkg::S_RESP:
            begin
                done       = 1'b1;
                state_next = scfl_pkg::S_IDLE;
            end
            default:
            begin
                state_next = scfl_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/size_class_free_list_allocator.sv
// Top level of the power-of-two size-class block manager.
// A request is captured in the idle state and decoded in the decode state, which registers
// the results; a pool hit adds a read state, and done is raised in the response state.
// A new request is taken only in the idle state, after the last one has been answered.
// A pool hit needs the read state for the registered read port of the stack memory.
// Reset clears all class depths and loads depth_limit with 64; the stack memory
// is not cleared, and requests are taken right after reset.
`timescale 1ns / 1ps

module size_class_free_list_allocator #(
    parameter int LOG_MIN_SIZE = scfl_pkg::LOG_MIN_SIZE_DEF,
    parameter int LOG_MAX_SIZE = scfl_pkg::LOG_MAX_SIZE_DEF,
    parameter int MAX_DEPTH    = scfl_pkg::MAX_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                command,
    input  logic [scfl_pkg::REQ_W-1:0]          request_bytes,
    input  logic [scfl_pkg::HANDLE_W-1:0]       block_handle,
    input  logic signed [scfl_pkg::CLASS_W-1:0] block_class,
    output logic                                done,
    output logic [2:0]                          status,
    output logic [scfl_pkg::HANDLE_W-1:0]       out_handle,
    output logic signed [scfl_pkg::CLASS_W-1:0] out_class,
    output logic [scfl_pkg::BYTES_W-1:0]        block_bytes,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [scfl_pkg::LIMIT_W-1:0]        cfg_data
);

    scfl_pkg::ctl_t ctl;
    scfl_pkg::sts_t sts;

    scfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_valid (cfg_valid),
        .sts       (sts),
        .ctl       (ctl),
        .busy      (busy),
        .done      (done),
        .cfg_ready (cfg_ready)
    );

    scfl_datapath #(
        .LOG_MIN_SIZE(LOG_MIN_SIZE),
        .LOG_MAX_SIZE(LOG_MAX_SIZE),
        .MAX_DEPTH   (MAX_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .command       (command),
        .request_bytes (request_bytes),
        .block_handle  (block_handle),
        .block_class   (block_class),
        .cfg_data      (cfg_data),
        .status        (status),
        .out_handle    (out_handle),
        .out_class     (out_class),
        .block_bytes   (block_bytes)
    );

endmodule

FILE: src/scfl_checker.sv
// Port-level checker for the size-class block manager and its bind to the top level.
`timescale 1ns / 1ps
`include "size_class_free_list_allocator_macros.svh"

module scfl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic [2:0]                    status,
    input logic [scfl_pkg::HANDLE_W-1:0] out_handle
);

    `SCFL_ASSERT_NXT(a_accept_then_busy, start && !busy, busy && !done)
    `SCFL_ASSERT_NXT(a_done_single_cycle, done, !done && !busy)
    `SCFL_ASSERT_IMP(a_status_known, done, status <= scfl_pkg::ST_NULL)
    `SCFL_ASSERT_IMP(a_handle_only_on_hit, done && (status != scfl_pkg::ST_HIT), out_handle == '0)

endmodule

bind size_class_free_list_allocator scfl_checker u_scfl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .out_handle (out_handle)
);
